// ===== rtl/circular_color_picker_mean_assert.svh =====
// Assertion macros for the circular colour picker mean block
`ifndef CIRCULAR_COLOR_PICKER_MEAN_ASSERT_SVH
`define CIRCULAR_COLOR_PICKER_MEAN_ASSERT_SVH

// same-cycle implication
`define CCPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CCPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ccpm_pkg.sv =====
// Types and constants for the circular colour picker mean block
package ccpm_pkg;

   localparam int DEFAULT_MAX_DIM    = 4096;
   localparam int DEFAULT_MAX_PICKER = 64;

   localparam int NUM_CH  = 6;
   localparam int CH_W    = 8;
   localparam int SUM_W   = 20;
   localparam int CNT_W   = 13;
   localparam int MEAN_W  = 16;
   localparam int QUO_W   = SUM_W + 8;
   localparam int COORD_W = 12;
   localparam int POS_W   = 14;
   localparam int SIZE_W  = 7;
   localparam int DIM_W   = 13;
   localparam int WIN_W   = 17;
   localparam int MUL_W   = 8;
   localparam int SQ_W    = 14;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_PICKER_X     = 3'd0;
   localparam logic [2:0] REG_PICKER_Y     = 3'd1;
   localparam logic [2:0] REG_PICKER_SIZE  = 3'd2;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

   localparam logic [SIZE_W-1:0] RESET_SIZE = 7'd8;
   localparam logic [DIM_W-1:0]  RESET_DIM  = 13'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR,
      ST_SQX,
      ST_SQY,
      ST_TEST,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } ccpm_state_type;

endpackage

// ===== rtl/circular_color_picker_mean.sv =====
// Top level of the circular colour picker mean block
// Each pixel item runs through accept, radius square, dx square, dy square and test.
// The squares share one 8x8 multiplier; no new item is taken until the test is done. On the last
// pixel a shared restoring divider forms the six means in turn; the result is held until taken.
// Synchronous reset: sums and count cleared, registers to their defaults, no clearing pass.
module circular_color_picker_mean #(
   parameter int MAX_DIM    = ccpm_pkg::DEFAULT_MAX_DIM,
   parameter int MAX_PICKER = ccpm_pkg::DEFAULT_MAX_PICKER
) (
   input  logic                                clock,
   input  logic                                reset,
   // pix_x, pix_y, true_red, true_green, true_blue, preview_red, preview_green, preview_blue
   input  logic [ccpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // true_red_mean, true_green_mean, true_blue_mean, preview_red_mean,
   // preview_green_mean, preview_blue_mean, sample_count, zero fill
   output logic [ccpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // in_view
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ccpm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ccpm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ccpm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ccpm_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_CAP = (MAX_PICKER > 127) ? 7'd127 : SIZE_W'(MAX_PICKER);
   localparam logic [DIM_W-1:0]  DIM_CAP  = (MAX_DIM > 8191) ? 13'h1FFF : DIM_W'(MAX_DIM);
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   // configuration
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [DIM_W-1:0]        width_ff, height_ff;
   logic                    csr_wr;
   logic [2:0]              csr_idx;

   // control and data path
   ccpm_state_type          state_ff, state_in;
   logic [MUL_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                    hit_win_ff, hit_win_in;
   logic                    view_ff, view_in;
   logic                    last_ff, last_in;
   logic [CH_W-1:0]         pix_ff [NUM_CH];
   logic [CH_W-1:0]         pix_in [NUM_CH];
   logic [SUM_W-1:0]        sum_ff [NUM_CH];
   logic [SUM_W-1:0]        sum_in [NUM_CH];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SQ_W-1:0]         rad2_ff, rad2_in, dist_ff, dist_in;
   logic [2:0]              ch_idx_ff, ch_idx_in;
   logic [4:0]              step_ff, step_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [MEAN_W-1:0]       mean_ff [NUM_CH];
   logic [MEAN_W-1:0]       mean_in [NUM_CH];
   logic [CNT_W-1:0]        cnt_out_ff, cnt_out_in;

   // window geometry
   logic [SIZE_W-1:0]       size_c;
   logic [DIM_W-1:0]        w_c, h_c;
   logic [5:0]              half;
   logic signed [WIN_W-1:0] left, top, right, bottom, wide_w, wide_h, px_s, py_s;
   logic signed [WIN_W-1:0] dx_wide, dy_wide;
   logic                    view_c, in_win_c;

   // shared units
   logic signed [MUL_W-1:0]     mul_a;
   logic signed [2*MUL_W-1:0]   mul_p;
   logic [SQ_W-1:0]             sq;
   logic [CNT_W-1:0]            div_w;
   logic [CNT_W:0]              trial, trial_sub;
   logic                        ge;
   logic [QUO_W-1:0]            quo_step;
   logic [MEAN_W-1:0]           mean_val;
   logic [SUM_W:0]              sum_add;
   logic                        accept;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      case (csr_idx)
         REG_PICKER_X:     csr_prdata = {18'b0, pos_x_ff};
         REG_PICKER_Y:     csr_prdata = {18'b0, pos_y_ff};
         REG_PICKER_SIZE:  csr_prdata = {25'b0, size_ff};
         REG_IMAGE_WIDTH:  csr_prdata = {19'b0, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {19'b0, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         size_ff   <= RESET_SIZE;
         width_ff  <= RESET_DIM;
         height_ff <= RESET_DIM;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_PICKER_X:     pos_x_ff  <= csr_pwdata[POS_W-1:0];
            REG_PICKER_Y:     pos_y_ff  <= csr_pwdata[POS_W-1:0];
            REG_PICKER_SIZE:  size_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // window and circle geometry
   assign size_c  = (size_ff > SIZE_CAP) ? SIZE_CAP : size_ff;
   assign w_c     = (width_ff > DIM_CAP) ? DIM_CAP : width_ff;
   assign h_c     = (height_ff > DIM_CAP) ? DIM_CAP : height_ff;
   assign half    = size_c[SIZE_W-1:1];
   assign left    = WIN_W'(pos_x_ff) - $signed({11'b0, half});
   assign top     = WIN_W'(pos_y_ff) - $signed({11'b0, half});
   assign right   = left + $signed({10'b0, size_c});
   assign bottom  = top + $signed({10'b0, size_c});
   assign wide_w  = $signed({4'b0, w_c});
   assign wide_h  = $signed({4'b0, h_c});
   assign px_s    = $signed({5'b0, req_tdata[11:0]});
   assign py_s    = $signed({5'b0, req_tdata[23:12]});
   assign view_c  = !(left > wide_w || top > wide_h || right < 0 || bottom < 0);
   assign in_win_c = view_c && px_s >= left && px_s < right && px_s < wide_w
                     && py_s >= top && py_s < bottom && py_s < wide_h;
   assign dx_wide = WIN_W'(pos_x_ff) - px_s;
   assign dy_wide = WIN_W'(pos_y_ff) - py_s;

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_SQR:  mul_a = $signed({2'b0, half});
         ST_SQX:  mul_a = $signed(dx_ff);
         ST_SQY:  mul_a = $signed(dy_ff);
         default: mul_a = '0;
      endcase
   end
   assign mul_p = mul_a * mul_a;
   assign sq    = mul_p[SQ_W-1:0];

   // shared divider step
   assign div_w     = (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign ge        = trial >= {1'b0, div_w};
   assign trial_sub = trial - {1'b0, div_w};
   assign quo_step  = {quo_ff[QUO_W-2:0], ge};
   assign mean_val  = (|quo_step[QUO_W-1:MEAN_W]) ? '1 : quo_step[MEAN_W-1:0];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tuser  = view_ff;
   assign rsp_tdata  = view_ff ? {3'b0, cnt_out_ff, mean_ff[5], mean_ff[4], mean_ff[3],
                                   mean_ff[2], mean_ff[1], mean_ff[0]} : '0;

   always_comb begin
      state_in   = state_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      hit_win_in = hit_win_ff;
      view_in    = view_ff;
      last_in    = last_ff;
      pix_in     = pix_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      rad2_in    = rad2_ff;
      dist_in    = dist_ff;
      ch_idx_in  = ch_idx_ff;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      mean_in    = mean_ff;
      cnt_out_in = cnt_out_ff;
      sum_add    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dx_in      = dx_wide[MUL_W-1:0];
               dy_in      = dy_wide[MUL_W-1:0];
               hit_win_in = in_win_c;
               view_in    = view_c;
               last_in    = req_tlast;
               for (int k = 0; k < NUM_CH; k++) begin
                  pix_in[k] = req_tdata[24 + CH_W*k +: CH_W];
               end
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            rad2_in  = sq;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            dist_in  = sq;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            dist_in  = dist_ff + sq;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (hit_win_ff && dist_ff <= rad2_ff) begin
               for (int k = 0; k < NUM_CH; k++) begin
                  sum_add   = {1'b0, sum_ff[k]} + {13'b0, pix_ff[k]};
                  sum_in[k] = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
               end
               if (cnt_ff != CNT_MAX) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ch_idx_in = '0;
            state_in  = last_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            quo_in   = {sum_ff[ch_idx_ff], 8'b0};
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in  = quo_step;
            rem_in  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(QUO_W - 1)) begin
               mean_in[ch_idx_ff] = mean_val;
               if (ch_idx_ff == 3'(NUM_CH - 1)) begin
                  cnt_out_in = cnt_ff;
                  for (int k = 0; k < NUM_CH; k++) begin
                     sum_in[k] = '0;
                  end
                  cnt_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  ch_idx_in = ch_idx_ff + 3'd1;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         for (int k = 0; k < NUM_CH; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      hit_win_ff <= hit_win_in;
      view_ff    <= view_in;
      last_ff    <= last_in;
      pix_ff     <= pix_in;
      rad2_ff    <= rad2_in;
      dist_ff    <= dist_in;
      ch_idx_ff  <= ch_idx_in;
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      mean_ff    <= mean_in;
      cnt_out_ff <= cnt_out_in;
   end

`include "circular_color_picker_mean_assert.svh"

   `CCPM_ASSERT_SAME(a_one_side, clock, reset, 1'b1, !(req_tready && rsp_tvalid), "ready while result pending")
   `CCPM_ASSERT_NEXT(a_busy_after_item, clock, reset, accept, !req_tready, "ready right after an item")
   `CCPM_ASSERT_SAME(a_rem_below_div, clock, reset, state_ff == ST_DIV, rem_ff < div_w, "divider remainder out of range")
   `CCPM_ASSERT_SAME(a_out_of_view_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "nonzero result out of view")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the circular colour picker mean block: directed rows, then random frames
`timescale 1ns / 1ps

module tb_top;
   import ccpm_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE      = 200;
   localparam int SUM_SAT     = (1 << SUM_W) - 1;
   localparam int CNT_SAT     = (1 << CNT_W) - 1;

   typedef struct packed {
      logic                         in_view;
      logic [NUM_CH-1:0][MEAN_W-1:0] mean;
      logic [CNT_W-1:0]             count;
   } means_type;

   typedef struct packed {
      logic [NUM_CH-1:0][CH_W-1:0] ch;
      logic [COORD_W-1:0]          y;
      logic [COORD_W-1:0]          x;
      logic                        last;
   } pixel_type;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  reg_idx;
      logic [31:0] value;
      pixel_type   pix;
      bit          typed;
      means_type   want;
   } dir_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // window registers as the block should hold them
   logic signed [POS_W-1:0] pick_x;
   logic signed [POS_W-1:0] pick_y;
   logic [SIZE_W-1:0]       pick_size;
   logic [DIM_W-1:0]        img_w;
   logic [DIM_W-1:0]        img_h;
   logic [SUM_W-1:0]        acc_sum [NUM_CH];
   logic [CNT_W-1:0]        acc_hits;

   means_type pending_means [$];
   int        fault_count = 0;
   bit        calm = 1'b0;
   string     field_name [NUM_CH] = '{"true_red_mean", "true_green_mean", "true_blue_mean",
                                      "preview_red_mean", "preview_green_mean",
                                      "preview_blue_mean"};

   circular_color_picker_mean i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      pick_x    = '0;
      pick_y    = '0;
      pick_size = RESET_SIZE;
      img_w     = RESET_DIM;
      img_h     = RESET_DIM;
      acc_hits  = '0;
      foreach (acc_sum[k]) acc_sum[k] = '0;
   end

   // accumulate one pixel; on the last pixel yield the means and clear
   function automatic bit accumulate_pixel(input pixel_type p, output means_type r);
      longint size, w, h, half, cx, cy, left, top, px, py, dx, dy, cnt, m;
      bit view;
      int unsigned s;
      size = (pick_size > DEFAULT_MAX_PICKER) ? DEFAULT_MAX_PICKER : pick_size;
      w    = (img_w > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : img_w;
      h    = (img_h > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : img_h;
      half = size / 2;
      cx   = pick_x;
      cy   = pick_y;
      left = cx - half;
      top  = cy - half;
      px   = p.x;
      py   = p.y;
      view = !(left > w || top > h || left + size < 0 || top + size < 0);
      if (view && px >= left && px < left + size && px < w &&
          py >= top && py < top + size && py < h) begin
         dx = cx - px;
         dy = cy - py;
         if (dx * dx + dy * dy <= half * half) begin
            for (int k = 0; k < NUM_CH; k++) begin
               s = acc_sum[k] + p.ch[k];
               acc_sum[k] = (s > SUM_SAT) ? SUM_SAT[SUM_W-1:0] : s[SUM_W-1:0];
            end
            if (acc_hits < CNT_SAT) acc_hits++;
         end
      end
      r = '0;
      if (!p.last) return 1'b0;
      cnt = acc_hits ? acc_hits : 1;
      r.in_view = view;
      for (int k = 0; k < NUM_CH; k++) begin
         m = (longint'(acc_sum[k]) << 8) / cnt;
         r.mean[k] = view ? ((m > 65535) ? 16'hFFFF : m[MEAN_W-1:0]) : '0;
      end
      r.count = view ? acc_hits : '0;
      for (int k = 0; k < NUM_CH; k++) acc_sum[k] = '0;
      acc_hits = '0;
      return 1'b1;
   endfunction

   task automatic note_fault(input string what, input int want, input int got);
      fault_count++;
      if (fault_count <= 10)
         $display("tb_top: mismatch %s expected %0d got %0d", what, want, got);
   endtask

   task automatic check_means(input means_type got);
      means_type want;
      if (pending_means.size() == 0) begin
         note_fault("unexpected result, in_view", 0, got.in_view);
         return;
      end
      want = pending_means.pop_front();
      if (got.in_view !== want.in_view) note_fault("in_view", want.in_view, got.in_view);
      for (int k = 0; k < NUM_CH; k++)
         if (got.mean[k] !== want.mean[k]) note_fault(field_name[k], want.mean[k], got.mean[k]);
      if (got.count !== want.count) note_fault("sample_count", want.count, got.count);
   endtask

   task automatic send_pixel(input pixel_type p, input bit typed, input means_type want);
      int gap;
      means_type got;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {p.ch, p.y, p.x};
      req_tlast  <= p.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (accumulate_pixel(p, got)) pending_means.push_back(typed ? want : got);
   endtask

   // drop valid, drain every outstanding result, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_means.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PICKER_X:     pick_x    = v[POS_W-1:0];
         REG_PICKER_Y:     pick_y    = v[POS_W-1:0];
         REG_PICKER_SIZE:  pick_size = v[SIZE_W-1:0];
         REG_IMAGE_WIDTH:  img_w     = v[DIM_W-1:0];
         REG_IMAGE_HEIGHT: img_h     = v[DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic dir_row_type px_row(input int x, input int y, input logic [47:0] ch,
                                          input bit last);
      dir_row_type r;
      r = '{default: '0};
      r.pix.x    = x[COORD_W-1:0];
      r.pix.y    = y[COORD_W-1:0];
      r.pix.ch   = ch;
      r.pix.last = last;
      return r;
   endfunction

   function automatic dir_row_type cf_row(input logic [2:0] idx, input logic [31:0] v);
      dir_row_type r;
      r = '{default: '0};
      r.is_cfg  = 1'b1;
      r.reg_idx = idx;
      r.value   = v;
      return r;
   endfunction

   function automatic dir_row_type typed_row(input int x, input int y, input logic [47:0] ch,
                                             input bit view, input logic [15:0] m,
                                             input logic [12:0] c);
      dir_row_type r;
      r = px_row(x, y, ch, 1'b1);
      r.typed        = 1'b1;
      r.want.in_view = view;
      r.want.mean    = {NUM_CH{m}};
      r.want.count   = c;
      return r;
   endfunction

   function automatic int near_coord(input int c, input int half);
      int v;
      v = c + int'($urandom_range(0, 2 * half + 2)) - (half + 1);
      if (v < 0 || v > 4095) v = $urandom_range(0, 4095);
      return v;
   endfunction

   function automatic pixel_type make_pixel(input bit last);
      pixel_type p;
      int half;
      half = pick_size / 2;
      if ($urandom_range(0, 4) == 0) begin
         p.x = COORD_W'($urandom_range(0, 4095));
         p.y = COORD_W'($urandom_range(0, 4095));
      end else begin
         p.x = COORD_W'(near_coord(pick_x, half));
         p.y = COORD_W'(near_coord(pick_y, half));
      end
      for (int k = 0; k < NUM_CH; k++)
         case ($urandom_range(0, 9))
            0:       p.ch[k] = 8'h00;
            1:       p.ch[k] = 8'hFF;
            default: p.ch[k] = CH_W'($urandom_range(0, 255));
         endcase
      p.last = last;
      return p;
   endfunction

   task automatic run_phase(input int items);
      int size_pool [7] = '{0, 1, 2, 63, 64, 65, 127};
      int dim_pool [5]  = '{0, 1, 4096, 4097, 8191};
      int pos_pool [4]  = '{-8192, 8191, -64, 4095};
      int size, w, h, ww, hh, x, y, sent, len;
      bit broken;
      size = ($urandom_range(0, 7) == 0) ? size_pool[$urandom_range(0, 6)]
                                         : $urandom_range(1, 64);
      case ($urandom_range(0, 9))
         0:       w = dim_pool[$urandom_range(0, 4)];
         1:       w = $urandom_range(0, 8191);
         default: w = $urandom_range(16, 4096);
      endcase
      case ($urandom_range(0, 9))
         0:       h = dim_pool[$urandom_range(0, 4)];
         1:       h = $urandom_range(0, 8191);
         default: h = $urandom_range(16, 4096);
      endcase
      ww = (w > 4096) ? 4096 : w;
      hh = (h > 4096) ? 4096 : h;
      case ($urandom_range(0, 9))
         0:       x = pos_pool[$urandom_range(0, 3)];
         1:       x = int'($urandom_range(0, 16383)) - 8192;
         default: x = int'($urandom_range(0, ww + size + 16)) - (size / 2 + 8);
      endcase
      case ($urandom_range(0, 9))
         0:       y = pos_pool[$urandom_range(0, 3)];
         1:       y = int'($urandom_range(0, 16383)) - 8192;
         default: y = int'($urandom_range(0, hh + size + 16)) - (size / 2 + 8);
      endcase
      wait_idle();
      cfg_write(REG_PICKER_SIZE, size);
      cfg_write(REG_IMAGE_WIDTH, w);
      cfg_write(REG_IMAGE_HEIGHT, h);
      cfg_write(REG_PICKER_X, x & 32'h3FFF);
      cfg_write(REG_PICKER_Y, y & 32'h3FFF);
      csr_idle();
      sent = 0;
      while (sent < items) begin
         len    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
         broken = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++)
            send_pixel(make_pixel((i == len - 1) && !broken), 1'b0, '0);
         sent += len;
      end
   endtask

   // long frame on one pixel at full scale
   task automatic run_long_frame();
      pixel_type p;
      wait_idle();
      cfg_write(REG_PICKER_X, 100);
      cfg_write(REG_PICKER_Y, 100);
      cfg_write(REG_PICKER_SIZE, 64);
      cfg_write(REG_IMAGE_WIDTH, 4096);
      cfg_write(REG_IMAGE_HEIGHT, 4096);
      csr_idle();
      for (int i = 0; i < 100; i++) begin
         p.x    = COORD_W'(100);
         p.y    = COORD_W'(100);
         p.ch   = '1;
         p.last = (i == 99);
         send_pixel(p, 1'b0, '0);
      end
   endtask

   initial begin : drain
      int stall;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_means({rsp_tuser, rsp_tdata[95:0], rsp_tdata[108:96]});
      end
   end

   initial begin : stimulus
      dir_row_type rows [$];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back(typed_row(0, 0, '1, 1'b1, 16'd65280, 13'd1));
      rows.push_back(typed_row(4095, 4095, '0, 1'b1, 16'd0, 13'd0));
      rows.push_back(px_row(4, 0, 48'h0102_0304_0506, 1'b0));
      rows.push_back(px_row(3, 3, 48'hFFFF_FFFF_FFFF, 1'b0));
      rows.push_back(px_row(0, 4095, 48'hFFFF_FFFF_FFFF, 1'b0));
      rows.push_back(px_row(0, 3, 48'h80FE_7F01_00C3, 1'b1));
      rows.push_back(cf_row(REG_PICKER_X, 32'h2000));
      rows.push_back(typed_row(0, 0, '1, 1'b0, 16'd0, 13'd0));
      rows.push_back(cf_row(REG_PICKER_X, 32'h1FFF));
      rows.push_back(typed_row(4095, 0, '1, 1'b0, 16'd0, 13'd0));
      rows.push_back(cf_row(REG_PICKER_X, 32'h0000));
      rows.push_back(cf_row(REG_PICKER_Y, 32'h1FFF));
      rows.push_back(typed_row(0, 4095, '1, 1'b0, 16'd0, 13'd0));
      rows.push_back(cf_row(REG_PICKER_Y, 32'h2000));
      rows.push_back(typed_row(0, 0, '1, 1'b0, 16'd0, 13'd0));
      rows.push_back(cf_row(REG_PICKER_Y, 32'h0000));
      rows.push_back(cf_row(REG_PICKER_SIZE, 32'd0));
      rows.push_back(typed_row(0, 0, '1, 1'b1, 16'd0, 13'd0));
      rows.push_back(cf_row(REG_PICKER_SIZE, 32'd127));
      rows.push_back(px_row(32, 0, 48'h1122_3344_5566, 1'b0));
      rows.push_back(px_row(20, 20, 48'hFF00_FF00_FF00, 1'b1));
      rows.push_back(cf_row(REG_IMAGE_WIDTH, 32'd0));
      rows.push_back(cf_row(REG_IMAGE_HEIGHT, 32'd0));
      rows.push_back(px_row(0, 0, '1, 1'b1));
      rows.push_back(cf_row(REG_IMAGE_WIDTH, 32'd8191));
      rows.push_back(cf_row(REG_IMAGE_HEIGHT, 32'd8191));
      rows.push_back(cf_row(REG_PICKER_SIZE, 32'd64));
      rows.push_back(cf_row(REG_PICKER_X, 32'd4095));
      rows.push_back(cf_row(REG_PICKER_Y, 32'd4095));
      rows.push_back(px_row(4095, 4095, 48'hAAAA_AAAA_AAAA, 1'b0));
      rows.push_back(px_row(4063, 4095, 48'h5555_5555_5555, 1'b0));
      rows.push_back(px_row(4095, 4063, 48'h0F0F_F0F0_7777, 1'b1));
      rows.push_back(cf_row(REG_IMAGE_WIDTH, 32'd1));
      rows.push_back(cf_row(REG_IMAGE_HEIGHT, 32'd1));
      rows.push_back(cf_row(REG_PICKER_SIZE, 32'd1));
      rows.push_back(cf_row(REG_PICKER_X, 32'd0));
      rows.push_back(cf_row(REG_PICKER_Y, 32'd0));
      rows.push_back(px_row(0, 0, 48'h9876_5432_10FE, 1'b0));
      rows.push_back(px_row(1, 0, 48'hFFFF_FFFF_FFFF, 1'b1));

      foreach (rows[i])
         if (rows[i].is_cfg) begin
            wait_idle();
            cfg_write(rows[i].reg_idx, rows[i].value);
            csr_idle();
         end else begin
            send_pixel(rows[i].pix, rows[i].typed, rows[i].want);
         end

      for (int ph = 0; ph < 24; ph++) begin
         calm = (ph % 5 == 4);
         run_phase(64);
         if (ph == 12) run_long_frame();
      end
      calm = 1'b0;
      wait_idle();

      if (fault_count == 0 && pending_means.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
